// ===== design/block_average_median_decimator_top_defines.svh =====
// Assertion macros shared by the decimator RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef BLOCK_AVERAGE_MEDIAN_DECIMATOR_TOP_DEFINES_SVH
`define BLOCK_AVERAGE_MEDIAN_DECIMATOR_TOP_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define BAMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be true out of reset.
`define BAMD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/bamd_pkg.sv =====
// Package for the block average / median decimator.
// Types, constants and sorting-network helpers; no dependencies.
`timescale 1ns / 1ps

package bamd_pkg;

  localparam int RNG_W      = 16;
  localparam int ANG_W      = 16;
  localparam int MAX_WINDOW = 8;
  localparam int MIN_WINDOW = 4;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int FILL_W     = 3;
  localparam int WIN_REGS   = MAX_WINDOW - 1;
  localparam int FIFO_DEPTH = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [1:0] WLOG_RESET = 2'd2;
  localparam logic [1:0] WLOG_8     = 2'd3;

  localparam logic [FILL_W-1:0] LAST_IDX_4 = FILL_W'(MIN_WINDOW - 1);
  localparam logic [FILL_W-1:0] LAST_IDX_8 = FILL_W'(MAX_WINDOW - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE = 1'b0,
    CFG_WINDOW_LOG2 = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    MODE_AVERAGE = 1'b0,
    MODE_MEDIAN  = 1'b1
  } mode_t;

  typedef logic [MAX_WINDOW-1:0][RNG_W-1:0] rng_vec_t;
  typedef logic [MAX_WINDOW-1:0][ANG_W-1:0] ang_vec_t;

  // One complete window handed from front to back.
  typedef struct packed {
    rng_vec_t rng;
    ang_vec_t ang;
    mode_t    mode;
    logic     w8;
  } job_t;

  // Compare-exchange: smaller value to position i.
  function automatic rng_vec_t cas(rng_vec_t v, logic [IDX_W-1:0] i,
                                   logic [IDX_W-1:0] j);
    rng_vec_t r;
    r = v;
    if (v[j] < v[i]) begin
      r[i] = v[j];
      r[j] = v[i];
    end
    return r;
  endfunction

  // Odd-even merge sort of eight, layers one and two.
  function automatic rng_vec_t sort_l12(rng_vec_t v);
    rng_vec_t r;
    r = cas(v, 3'd0, 3'd1);
    r = cas(r, 3'd2, 3'd3);
    r = cas(r, 3'd4, 3'd5);
    r = cas(r, 3'd6, 3'd7);
    r = cas(r, 3'd0, 3'd2);
    r = cas(r, 3'd1, 3'd3);
    r = cas(r, 3'd4, 3'd6);
    r = cas(r, 3'd5, 3'd7);
    return r;
  endfunction

  // Layers three and four.
  function automatic rng_vec_t sort_l34(rng_vec_t v);
    rng_vec_t r;
    r = cas(v, 3'd1, 3'd2);
    r = cas(r, 3'd5, 3'd6);
    r = cas(r, 3'd0, 3'd4);
    r = cas(r, 3'd1, 3'd5);
    r = cas(r, 3'd2, 3'd6);
    r = cas(r, 3'd3, 3'd7);
    return r;
  endfunction

  // Layers five and six.
  function automatic rng_vec_t sort_l56(rng_vec_t v);
    rng_vec_t r;
    r = cas(v, 3'd2, 3'd4);
    r = cas(r, 3'd3, 3'd5);
    r = cas(r, 3'd1, 3'd2);
    r = cas(r, 3'd3, 3'd4);
    r = cas(r, 3'd5, 3'd6);
    return r;
  endfunction

endpackage

// ===== design/bamd_if.sv =====
// Valid/ready channel interfaces for scan points and filtered points.
// Widths come from bamd_pkg.
`timescale 1ns / 1ps

interface bamd_in_if;
  logic                             valid;
  logic                             ready;
  logic [bamd_pkg::RNG_W-1:0]       range_mm;
  logic signed [bamd_pkg::ANG_W-1:0] angle_code;
  logic                             scan_last;

  modport source(output valid, output range_mm, output angle_code, output scan_last,
                 input ready);
  modport sink(input valid, input range_mm, input angle_code, input scan_last,
               output ready);
endinterface

interface bamd_out_if;
  logic                             valid;
  logic                             ready;
  logic [bamd_pkg::RNG_W-1:0]       filtered_range_mm;
  logic signed [bamd_pkg::ANG_W-1:0] filtered_angle_code;

  modport source(output valid, output filtered_range_mm, output filtered_angle_code,
                 input ready);
  modport sink(input valid, input filtered_range_mm, input filtered_angle_code,
               output ready);
endinterface

// ===== design/block_average_median_decimator_top.sv =====
// Top level of the block average / median decimator.
// Depends on bamd_pkg, bamd_if, bamd_front, bamd_fifo and bamd_back.
`timescale 1ns / 1ps
//
// Usage:
//   in_ch  : scan points (range_mm, angle_code, scan_last), valid/ready.
//   out_ch : one filtered point per completed window of 4 or 8 points.
//   cfg_*  : write port; index 0 = filter_mode (0 average, 1 median),
//            index 1 = window_log2 (3 selects 8 points, anything else 4).
//            Writing window_log2 drops the partial window. Write only idle.
// Throughput: one input item per cycle while the queue is not full. The front end stores
//   each point in a flop window and issues a job when a window completes;
//   a two-entry job queue decouples it from the back end.
// Path: after the edge that accepts the window's last point, the result
//   passes the queue, sort/sum and final stage to out_ch.valid.
// The back end is a three-stage pipeline (sum tree or 8-input odd-even
//   merge sort, two layers a stage), one job per cycle unless stalled.
// Reset (rst_n low, synchronous): empty window, empty queue, no result,
//   filter_mode = average, window_log2 = 2.
// Stall: a waiting result holds on out_ch; the pipeline and queue keep
//   filling, and in_ch.ready drops only while the queue holds two jobs.

module block_average_median_decimator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bamd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bamd_pkg::CFG_DATA_W-1:0]  cfg_data,
  bamd_in_if.sink                          in_ch,
  bamd_out_if.source                       out_ch
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  bamd_pkg::job_t q_job_in;
  bamd_pkg::job_t q_job_out;

  // Capture points, hold configuration, issue completed windows.
  bamd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job_in)
  );

  // Buffer jobs so front and back stall independently.
  bamd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_job_out)
  );

  // Reduce each window to one point and drive the result channel.
  bamd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_job_out),
    .job_ready (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/bamd_front.sv =====
// Front end: configuration registers, window capture, job issue.
// Depends on bamd_pkg and bamd_in_if.
`timescale 1ns / 1ps
`include "block_average_median_decimator_top_defines.svh"

module bamd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bamd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bamd_pkg::CFG_DATA_W-1:0]     cfg_data,
  bamd_in_if.sink                             in_ch,
  input  logic                                q_full,
  output logic                                q_push,
  output bamd_pkg::job_t                      q_job
);

  bamd_pkg::mode_t                  mode_r;
  logic [1:0]                       wlog_r;
  logic [bamd_pkg::FILL_W-1:0]      fill_r;
  logic [bamd_pkg::FILL_W-1:0]      fill_nxt;
  logic [bamd_pkg::RNG_W-1:0]       rwin_r [bamd_pkg::WIN_REGS];
  logic [bamd_pkg::ANG_W-1:0]       awin_r [bamd_pkg::WIN_REGS];
  logic                             w8;
  logic                             acc;
  logic                             complete;

  assign w8       = (wlog_r == bamd_pkg::WLOG_8);
  assign in_ch.ready = !q_full;
  assign acc      = in_ch.valid && in_ch.ready;
  assign complete = (fill_r == (w8 ? bamd_pkg::LAST_IDX_8 : bamd_pkg::LAST_IDX_4));
  assign q_push   = acc && complete;

  always_comb begin
    if (complete || in_ch.scan_last) begin
      fill_nxt = '0;
    end else begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  // Assemble the job: held entries plus the completing item at its slot.
  always_comb begin
    for (int i = 0; i < bamd_pkg::WIN_REGS; i++) begin
      if (fill_r == bamd_pkg::FILL_W'(i)) begin
        q_job.rng[i] = in_ch.range_mm;
        q_job.ang[i] = in_ch.angle_code;
      end else begin
        q_job.rng[i] = rwin_r[i];
        q_job.ang[i] = awin_r[i];
      end
    end
    q_job.rng[bamd_pkg::MAX_WINDOW-1] = in_ch.range_mm;
    q_job.ang[bamd_pkg::MAX_WINDOW-1] = in_ch.angle_code;
    q_job.mode = mode_r;
    q_job.w8   = w8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      mode_r <= bamd_pkg::MODE_AVERAGE;
      wlog_r <= bamd_pkg::WLOG_RESET;
    end else begin
      // A window-length write drops the partial window.
      if (cfg_we && (bamd_pkg::cfg_idx_t'(cfg_index) == bamd_pkg::CFG_WINDOW_LOG2)) begin
        fill_r <= '0;
      end else if (acc) begin
        fill_r <= fill_nxt;
      end
      if (cfg_we) begin
        case (bamd_pkg::cfg_idx_t'(cfg_index))
          bamd_pkg::CFG_FILTER_MODE: begin
            mode_r <= bamd_pkg::mode_t'(cfg_data[0]);
          end
          bamd_pkg::CFG_WINDOW_LOG2: begin
            wlog_r <= cfg_data[1:0];
          end
          default: begin
            mode_r <= mode_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !complete) begin
      rwin_r[fill_r] <= in_ch.range_mm;
      awin_r[fill_r] <= in_ch.angle_code;
    end
  end

  `BAMD_ASSERT(a_fill_in_window, !w8 |-> (fill_r < bamd_pkg::LAST_IDX_4 + 1'b1), "fill past short window")

endmodule

// ===== design/bamd_fifo.sv =====
// Two-entry job queue between front and back.
// Depends on bamd_pkg.
`timescale 1ns / 1ps
`include "block_average_median_decimator_top_defines.svh"

module bamd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bamd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bamd_pkg::job_t head_job
);

  localparam int PTR_W = $clog2(bamd_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(bamd_pkg::FIFO_DEPTH + 1);

  bamd_pkg::job_t    mem_r [bamd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_pop;

  assign full       = (count_r == CNT_W'(bamd_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `BAMD_NEVER(a_no_push_full, push && full, "job pushed into full queue")
  `BAMD_ASSERT(a_count_bound, count_r <= CNT_W'(bamd_pkg::FIFO_DEPTH), "queue count overflow")

endmodule

// ===== design/bamd_back.sv =====
// Back end: three-stage reduction (sum tree or sorting network) per job.
// Depends on bamd_pkg and bamd_out_if.
`timescale 1ns / 1ps
`include "block_average_median_decimator_top_defines.svh"

module bamd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  bamd_pkg::job_t job,
  output logic           job_ready,
  bamd_out_if.source     out_ch
);

  localparam int PS_W = bamd_pkg::RNG_W + 1;
  localparam int TS_W = bamd_pkg::RNG_W + 3;

  // stage 1
  logic                               v1_r;
  bamd_pkg::rng_vec_t                 s1_rng_r;
  logic [3:0][PS_W-1:0]               s1_rp_r;
  logic [3:0][PS_W-1:0]               s1_ap_r;
  logic signed [PS_W-1:0]             s1_mid_r;
  bamd_pkg::mode_t                    s1_mode_r;
  logic                               s1_w8_r;
  // stage 2
  logic                               v2_r;
  bamd_pkg::rng_vec_t                 s2_rng_r;
  logic [TS_W-1:0]                    s2_rsum_r;
  logic signed [TS_W-1:0]             s2_asum_r;
  logic signed [PS_W-1:0]             s2_mid_r;
  bamd_pkg::mode_t                    s2_mode_r;
  logic                               s2_w8_r;
  // stage 3 (output)
  logic                               v3_r;
  logic [bamd_pkg::RNG_W-1:0]         o_rng_r;
  logic [bamd_pkg::ANG_W-1:0]         o_ang_r;

  logic                               rdy1;
  logic                               rdy2;
  logic                               rdy3;

  bamd_pkg::rng_vec_t                 srt_in;
  bamd_pkg::rng_vec_t                 rz;
  bamd_pkg::ang_vec_t                 az;
  logic [3:0][PS_W-1:0]               rp_nxt;
  logic [3:0][PS_W-1:0]               ap_nxt;
  logic signed [PS_W-1:0]             mid_nxt;
  logic [TS_W-1:0]                    rsum_nxt;
  logic signed [TS_W-1:0]             asum_nxt;
  bamd_pkg::rng_vec_t                 s3_rng;
  logic [PS_W-1:0]                    med_sum;
  logic [bamd_pkg::RNG_W-1:0]         o_rng_nxt;
  logic [bamd_pkg::ANG_W-1:0]         o_ang_nxt;

  assign rdy3      = !v3_r || out_ch.ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign job_ready = rdy1;

  // Short window: pad the sort with max values and the sums with zero.
  always_comb begin
    for (int i = 0; i < bamd_pkg::MAX_WINDOW; i++) begin
      if (i >= bamd_pkg::MIN_WINDOW && !job.w8) begin
        srt_in[i] = '1;
        rz[i]     = '0;
        az[i]     = '0;
      end else begin
        srt_in[i] = job.rng[i];
        rz[i]     = job.rng[i];
        az[i]     = job.ang[i];
      end
    end
    for (int k = 0; k < 4; k++) begin
      rp_nxt[k] = {1'b0, rz[2*k]} + {1'b0, rz[2*k+1]};
      ap_nxt[k] = {az[2*k][bamd_pkg::ANG_W-1], az[2*k]}
                + {az[2*k+1][bamd_pkg::ANG_W-1], az[2*k+1]};
    end
    if (job.w8) begin
      mid_nxt = $signed({job.ang[3][bamd_pkg::ANG_W-1], job.ang[3]})
              + $signed({job.ang[4][bamd_pkg::ANG_W-1], job.ang[4]});
    end else begin
      mid_nxt = $signed({job.ang[1][bamd_pkg::ANG_W-1], job.ang[1]})
              + $signed({job.ang[2][bamd_pkg::ANG_W-1], job.ang[2]});
    end
  end

  always_comb begin
    rsum_nxt = TS_W'(s1_rp_r[0]) + TS_W'(s1_rp_r[1])
             + TS_W'(s1_rp_r[2]) + TS_W'(s1_rp_r[3]);
    asum_nxt = TS_W'($signed(s1_ap_r[0])) + TS_W'($signed(s1_ap_r[1]))
             + TS_W'($signed(s1_ap_r[2])) + TS_W'($signed(s1_ap_r[3]));
  end

  always_comb begin
    s3_rng = bamd_pkg::sort_l56(s2_rng_r);
    if (s2_w8_r) begin
      med_sum = {1'b0, s3_rng[3]} + {1'b0, s3_rng[4]};
    end else begin
      med_sum = {1'b0, s3_rng[1]} + {1'b0, s3_rng[2]};
    end
    case (s2_mode_r)
      bamd_pkg::MODE_MEDIAN: begin
        o_rng_nxt = med_sum[PS_W-1:1];
        o_ang_nxt = s2_mid_r[PS_W-1:1];
      end
      default: begin
        if (s2_w8_r) begin
          o_rng_nxt = s2_rsum_r[TS_W-1:3];
          o_ang_nxt = s2_asum_r[TS_W-1:3];
        end else begin
          o_rng_nxt = s2_rsum_r[TS_W-2:2];
          o_ang_nxt = s2_asum_r[TS_W-2:2];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= job_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_rng_r  <= bamd_pkg::sort_l12(srt_in);
      s1_rp_r   <= rp_nxt;
      s1_ap_r   <= ap_nxt;
      s1_mid_r  <= mid_nxt;
      s1_mode_r <= job.mode;
      s1_w8_r   <= job.w8;
    end
    if (rdy2) begin
      s2_rng_r  <= bamd_pkg::sort_l34(s1_rng_r);
      s2_rsum_r <= rsum_nxt;
      s2_asum_r <= asum_nxt;
      s2_mid_r  <= s1_mid_r;
      s2_mode_r <= s1_mode_r;
      s2_w8_r   <= s1_w8_r;
    end
    if (rdy3) begin
      o_rng_r <= o_rng_nxt;
      o_ang_r <= o_ang_nxt;
    end
  end

  assign out_ch.valid               = v3_r;
  assign out_ch.filtered_range_mm   = o_rng_r;
  assign out_ch.filtered_angle_code = o_ang_r;

  `BAMD_ASSERT(a_s2_hold, (v2_r && !rdy3) |=> (v2_r && $stable(s2_rsum_r) && $stable(s2_mid_r)), "stage 2 lost while stalled")

endmodule
